// ===== rtl/core/swrc_pkg.sv =====
// ----------------------------------------------------------------------------
// Stack with radix conversion: shared package
// Depth, field widths, action and status codes, and the beat types of the
// request and response channels.
// ----------------------------------------------------------------------------
`default_nettype none

package swrc_pkg;

   // Stack depth and the widths that follow from it.
   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // Field widths.
   localparam int DATA_W   = 32;
   localparam int NUM_W    = 31;
   localparam int BASE_W   = 4;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;

   // Accepted radix range.
   localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
   localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(10);

   // Action codes.
   localparam logic [ACTION_W-1:0] ACT_PUSH    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_POP     = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CONVERT = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_BASE  = 2'd3;

   typedef struct packed {
      logic [ACTION_W-1:0]      action;
      logic signed [DATA_W-1:0] value;
      logic [NUM_W-1:0]         number;
      logic [BASE_W-1:0]        base;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] element;
      logic                     is_empty;
      logic [STATUS_W-1:0]      status;
      logic                     last;
   } rsp_type;

   // Divider status seen by the sequencer.
   typedef struct packed {
      logic              done;
      logic [NUM_W-1:0]  quotient;
      logic [BASE_W-1:0] remainder;
   } div_result_type;

endpackage

`default_nettype wire

// ===== rtl/core/swrc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module swrc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/swrc_div.sv =====
// ----------------------------------------------------------------------------
// Bit-serial radix divider
// Restoring division of the number by the base, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module swrc_div
   import swrc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [NUM_W-1:0]  dividend,
   input  wire logic [BASE_W-1:0] divisor,
   output      div_result_type    result
);

   localparam int STEP_W = $clog2(NUM_W);

   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [BASE_W-1:0] rem_ff, rem_in;
   logic [BASE_W-1:0] base_ff, base_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [BASE_W:0]   trial;
   logic [BASE_W:0]   diff;
   logic              fits;

   always_comb begin
      // The dividend shifts out at the top while quotient bits shift in below.
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      diff    = trial - {1'b0, base_ff};
      fits    = trial >= {1'b0, base_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      base_in = base_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         base_in = divisor;
         step_in = STEP_W'(NUM_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUM_W-2:0], fits};
         rem_in = fits ? diff[BASE_W-1:0] : trial[BASE_W-1:0];
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      base_ff <= base_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign result.done      = done_ff;
   assign result.quotient  = quo_ff;
   assign result.remainder = rem_ff;

`ifndef SYNTHESIS
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider reports done while still busy");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted in the middle of a digit");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/stack_with_radix_conversion_top.sv =====
// Push, pop of an empty or one-entry stack and a rejected base load the result
// beat on acceptance; the result beat is valid the cycle after the request.
// Action 3 is taken and gives no beat. A pop that leaves entries needs a stack
// read and passes through S_POP_RD and S_POP_OUT before its beat. A convert runs
// each digit through the bit-serial divider and pushes it, then drains every entry.
// Reset clears control state and the entry count; stack memory is not cleared.
// ----------------------------------------------------------------------------
// Stack with radix conversion, top level
// Bounded LIFO stack of signed words with a convert action that splits a
// number into base 2..10 digits, pushes them and drains the whole stack.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_with_radix_conversion_top
   import swrc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_ready,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      rsp_type rsp_data
);

   // The sequencer walks one request at a time. Pops that leave entries and
   // the drain of a convert read the stack memory, whose read is registered,
   // so each such beat passes through a read state and an output state.
   typedef enum logic [2:0] {
      S_IDLE,
      S_POP_RD,
      S_POP_OUT,
      S_CONV_DIV,
      S_DRAIN_RD,
      S_DRAIN_OUT
   } state_type;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [DATA_W-1:0] top_ff, top_in;
   logic [STATUS_W-1:0]      st_ff, st_in;
   logic [BASE_W-1:0]        base_ff, base_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic                     out_free;
   logic                     accept;
   logic                     rsp_load;
   logic                     full;
   logic                     base_ok;
   logic [CNT_W-1:0]         cnt_dec;
   logic signed [DATA_W-1:0] top_elem;

   logic                     wr_en;
   logic [ADDR_W-1:0]        wr_addr;
   logic [DATA_W-1:0]        wr_data;
   logic [ADDR_W-1:0]        rd_addr;
   logic [DATA_W-1:0]        rd_data;

   logic                     div_start;
   logic [NUM_W-1:0]         div_dividend;
   logic [BASE_W-1:0]        div_divisor;
   div_result_type           div_res;

   swrc_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   swrc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .result   (div_res)
   );

   // The output register may be reloaded in the same cycle its beat is taken.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   assign full     = count_ff == CNT_W'(DEPTH);
   assign base_ok  = req_data.base inside {[BASE_MIN:BASE_MAX]};
   assign cnt_dec  = count_ff - CNT_W'(1);
   assign top_elem = (count_ff == '0) ? '0 : top_ff;

   // The read address always points at the current top entry. After a pop has
   // lowered the count, that is the new top; during the drain it is the next
   // entry to be sent.
   assign rd_addr = cnt_dec[ADDR_W-1:0];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      top_in       = top_ff;
      st_in        = st_ff;
      base_in      = base_ff;
      rsp_load     = 1'b0;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[ADDR_W-1:0];
      wr_data      = req_data.value;
      div_start    = 1'b0;
      div_dividend = req_data.number;
      div_divisor  = req_data.base;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.action)
                  ACT_PUSH: begin
                     rsp_load             = 1'b1;
                     rsp_data_in.is_empty = 1'b0;
                     rsp_data_in.last     = 1'b1;
                     if (full) begin
                        // The word is dropped; the old top stays in view.
                        rsp_data_in.element = top_ff;
                        rsp_data_in.status  = STATUS_FULL;
                     end else begin
                        wr_en               = 1'b1;
                        count_in            = count_ff + CNT_W'(1);
                        top_in              = req_data.value;
                        rsp_data_in.element = req_data.value;
                        rsp_data_in.status  = STATUS_OK;
                     end
                  end
                  ACT_POP: begin
                     if (count_ff == '0) begin
                        rsp_load             = 1'b1;
                        rsp_data_in.element  = '0;
                        rsp_data_in.is_empty = 1'b1;
                        rsp_data_in.status   = STATUS_POP_EMPTY;
                        rsp_data_in.last     = 1'b1;
                     end else if (count_ff == CNT_W'(1)) begin
                        count_in             = '0;
                        rsp_load             = 1'b1;
                        rsp_data_in.element  = '0;
                        rsp_data_in.is_empty = 1'b1;
                        rsp_data_in.status   = STATUS_OK;
                        rsp_data_in.last     = 1'b1;
                     end else begin
                        count_in = cnt_dec;
                        state_in = S_POP_RD;
                     end
                  end
                  ACT_CONVERT: begin
                     if (base_ok) begin
                        // The request bus may move on once the beat is taken,
                        // so the base is kept for the later digits.
                        div_start = 1'b1;
                        base_in   = req_data.base;
                        st_in     = STATUS_OK;
                        state_in  = S_CONV_DIV;
                     end else begin
                        rsp_load             = 1'b1;
                        rsp_data_in.element  = top_elem;
                        rsp_data_in.is_empty = count_ff == '0;
                        rsp_data_in.status   = STATUS_BAD_BASE;
                        rsp_data_in.last     = 1'b1;
                     end
                  end
                  default: begin
                     // Unused action code: taken and ignored.
                  end
               endcase
            end
         end
         S_POP_RD: begin
            state_in = S_POP_OUT;
         end
         S_POP_OUT: begin
            if (out_free) begin
               top_in               = rd_data;
               rsp_load             = 1'b1;
               rsp_data_in.element  = rd_data;
               rsp_data_in.is_empty = 1'b0;
               rsp_data_in.status   = STATUS_OK;
               rsp_data_in.last     = 1'b1;
               state_in             = S_IDLE;
            end
         end
         S_CONV_DIV: begin
            // Each finished division yields one digit, least significant
            // first. A zero number still yields one zero digit.
            div_dividend = div_res.quotient;
            div_divisor  = base_ff;
            wr_data      = DATA_W'(div_res.remainder);
            if (div_res.done) begin
               if (full) begin
                  st_in = STATUS_FULL;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
               if (div_res.quotient == '0) begin
                  state_in = S_DRAIN_RD;
               end else begin
                  div_start = 1'b1;
               end
            end
         end
         S_DRAIN_RD: begin
            state_in = S_DRAIN_OUT;
         end
         S_DRAIN_OUT: begin
            if (out_free) begin
               rsp_load             = 1'b1;
               rsp_data_in.element  = rd_data;
               rsp_data_in.is_empty = count_ff == CNT_W'(1);
               rsp_data_in.status   = st_ff;
               rsp_data_in.last     = count_ff == CNT_W'(1);
               count_in             = cnt_dec;
               state_in             = (count_ff == CNT_W'(1)) ? S_IDLE : S_DRAIN_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      top_ff      <= top_in;
      st_ff       <= st_in;
      base_ff     <= base_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count exceeds the stack depth");
   a_div_done_in_conv: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> state_ff == S_CONV_DIV)
      else $error("divider finished outside a convert");
   a_drain_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN_OUT && rsp_load && count_ff == CNT_W'(1))
      |=> (count_ff == '0 && state_ff == S_IDLE))
      else $error("stack not empty after the final drain beat");
   a_conv_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.action == ACT_CONVERT && base_ok)
      |=> (state_ff == S_CONV_DIV && !req_ready))
      else $error("convert did not enter the division sequence");
`endif

endmodule

`default_nettype wire
